[design/pppd_pkg.sv]
// pppd_pkg: types, widths and helper functions for the polyline point-at-distance core
// no dependencies; used by polyline_point_at_distance_core, pppd_checker and tb_top
package pppd_pkg;

    localparam int COORD_W    = 32;
    localparam int DIST_W     = 48;
    localparam int FRAC_BITS  = 8;
    localparam int MAG_W      = COORD_W + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int ACC_W      = MAG_W + DIST_W;
    localparam int ROOT_W     = 51;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 5;
    localparam int MUL_STEPS  = MAG_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = ACC_W;
    localparam int STEP_W     = 7;
    localparam int INT_W      = COORD_W + 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      path_end;
    } pppd_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] found_x;
        logic signed [COORD_W-1:0] found_y;
        logic [DIST_W-1:0]         trim_length;
        logic                      is_valid;
    } pppd_out_t;

    // p + d*take/len truncated toward zero, from quotient magnitude and sign of d
    function automatic logic [COORD_W-1:0] interp_fix(input logic [COORD_W-1:0] p,
                                                      input logic neg,
                                                      input logic [MAG_W-1:0] q,
                                                      input logic inexact);
        logic [INT_W-1:0] pe;
        logic [INT_W-1:0] qe;
        logic [INT_W-1:0] ix;
        logic [INT_W-1:0] fl;
        logic [INT_W-1:0] ce;
        logic [INT_W-1:0] s;
        pe = {{(INT_W-COORD_W){p[COORD_W-1]}}, p};
        qe = {{(INT_W-MAG_W){1'b0}}, q};
        ix = {{(INT_W-1){1'b0}}, inexact};
        if (neg) begin
            fl = -qe - ix;
            ce = -qe;
        end else begin
            fl = qe;
            ce = qe + ix;
        end
        s = pe + fl;
        if (s[INT_W-1]) begin
            s = pe + ce;
        end
        return s[COORD_W-1:0];
    endfunction

    // result when the path ends before the target is reached
    function automatic pppd_out_t end_result(input logic [COORD_W-1:0] px,
                                             input logic [COORD_W-1:0] py,
                                             input logic [COORD_W-1:0] sx,
                                             input logic [COORD_W-1:0] sy,
                                             input logic [DIST_W-1:0] trav);
        pppd_out_t r;
        r = '0;
        if (trav != '0 && (px != sx || py != sy)) begin
            r.found_x     = px;
            r.found_y     = py;
            r.trim_length = trav;
            r.is_valid    = 1'b1;
        end
        return r;
    endfunction

endpackage

[design/polyline_point_at_distance_core.sv]
// polyline_point_at_distance_core: finds the point at a set arc length along a point stream
// depends on pppd_pkg (types, widths, interpolation helpers)
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | pppd_in_t  (point_x, point_y, path_end)
//  m_      | out       | m_valid / m_ready  | pppd_out_t (found_x, found_y, trim_length, is_valid)
//  cfg_    | in        | cfg_wr_en          | cfg_wr_data (target_distance)
//
// a point that opens, repeats or follows a finished path is handled in S_IDLE (then S_EMIT if it gives an item)
// a new segment goes through S_PREP, the shift-add squares in S_MUL, S_SUMQ, the bit-serial root in S_SQRT and S_CMP
// a segment that reaches the target adds the multiply steps in S_IMUL, the divide steps in S_IDIV and S_FIN
// the single shift-add/restoring datapath works on one point at a time
// aresetn is synchronous; it clears the target and all per-path state
// a result waiting on m_ready does not stop the next point from being accepted, but a second result holds input
module polyline_point_at_distance_core
    import pppd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [DIST_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  pppd_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pppd_out_t         m_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_MUL, S_SUMQ, S_SQRT, S_CMP, S_IMUL, S_IDIV, S_FIN, S_EMIT
    } state_t;

    state_t             state_reg;
    logic [DIST_W-1:0]  target_reg;
    logic [COORD_W-1:0] start_x_reg, start_y_reg, prev_x_reg, prev_y_reg;
    logic [COORD_W-1:0] cur_x_reg, cur_y_reg;
    logic [DIST_W-1:0]  trav_reg;
    logic [1:0]         pts_reg;
    logic               sent_reg;
    logic               last_reg;
    logic               negx_reg, negy_reg;
    logic [MAG_W-1:0]   magx_reg, magy_reg;
    logic [MAG_W-1:0]   mbx_reg, mby_reg;
    logic [ACC_W-1:0]   accx_reg, accy_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [DIST_W-1:0]  take_reg;
    logic [MAG_W-1:0]   qx_reg, qy_reg;
    logic [ROOT_W-1:0]  rx_reg, ry_reg;
    pppd_out_t          pend_reg;
    logic               m_valid_reg;
    pppd_out_t          m_data_reg;

    logic [MAG_W-1:0]   dx, dy, adx, ady;
    logic [ACC_W-1:0]   mulax, mulay, addx, addy;
    logic [SQ_W:0]      sqsum;
    logic [REM_W-1:0]   rem_sh, trial;
    logic               sq_ge;
    logic [ROOT_W:0]    rsx, rsy;
    logic               gex, gey;
    logic [DIST_W-1:0]  remaining;
    logic               reach;
    logic [DIST_W-1:0]  trav_sum;
    logic [COORD_W-1:0] fx, fy;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        dx = {cur_x_reg[COORD_W-1], cur_x_reg} - {prev_x_reg[COORD_W-1], prev_x_reg};
        dy = {cur_y_reg[COORD_W-1], cur_y_reg} - {prev_y_reg[COORD_W-1], prev_y_reg};
        adx = dx[MAG_W-1] ? -dx : dx;
        ady = dy[MAG_W-1] ? -dy : dy;

        // multiplicand is take in the interpolation pass, the magnitude for squares
        if (state_reg == S_IMUL) begin
            mulax = ACC_W'(take_reg);
            mulay = ACC_W'(take_reg);
        end else begin
            mulax = ACC_W'(magx_reg);
            mulay = ACC_W'(magy_reg);
        end
        addx = {accx_reg[ACC_W-2:0], 1'b0} + (mbx_reg[MAG_W-1] ? mulax : '0);
        addy = {accy_reg[ACC_W-2:0], 1'b0} + (mby_reg[MAG_W-1] ? mulay : '0);

        sqsum  = {1'b0, accx_reg[SQ_W-1:0]} + {1'b0, accy_reg[SQ_W-1:0]};
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_reg, 2'b01};
        sq_ge  = (rem_sh >= trial);

        rsx = {rx_reg, accx_reg[ACC_W-1]};
        rsy = {ry_reg, accy_reg[ACC_W-1]};
        gex = (rsx >= {1'b0, root_reg});
        gey = (rsy >= {1'b0, root_reg});

        remaining = target_reg - trav_reg;
        reach     = ({{(ROOT_W-DIST_W){1'b0}}, remaining} <= root_reg);
        trav_sum  = trav_reg + root_reg[DIST_W-1:0];

        fx = interp_fix(prev_x_reg, negx_reg, qx_reg, rx_reg != '0);
        fy = interp_fix(prev_y_reg, negy_reg, qy_reg, ry_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            target_reg  <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            trav_reg    <= '0;
            pts_reg     <= '0;
            sent_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
            if (state_reg == S_EMIT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cur_x_reg <= s_data.point_x;
                        cur_y_reg <= s_data.point_y;
                        last_reg  <= s_data.path_end;
                        if (sent_reg) begin
                            // rest of the path is ignored
                            if (s_data.path_end) begin
                                start_x_reg <= '0;
                                start_y_reg <= '0;
                                prev_x_reg  <= '0;
                                prev_y_reg  <= '0;
                                trav_reg    <= '0;
                                pts_reg     <= '0;
                                sent_reg    <= 1'b0;
                            end
                        end else if (pts_reg == 2'd0) begin
                            if (s_data.path_end) begin
                                // single point path
                                start_x_reg <= '0;
                                start_y_reg <= '0;
                                prev_x_reg  <= '0;
                                prev_y_reg  <= '0;
                                trav_reg    <= '0;
                                pts_reg     <= '0;
                                sent_reg    <= 1'b0;
                                pend_reg    <= '0;
                                state_reg   <= S_EMIT;
                            end else begin
                                start_x_reg <= s_data.point_x;
                                start_y_reg <= s_data.point_y;
                                prev_x_reg  <= s_data.point_x;
                                prev_y_reg  <= s_data.point_y;
                                trav_reg    <= '0;
                                pts_reg     <= 2'd1;
                                if (target_reg == '0) begin
                                    pend_reg  <= '0;
                                    sent_reg  <= 1'b1;
                                    state_reg <= S_EMIT;
                                end
                            end
                        end else if (s_data.point_x == prev_x_reg &&
                                     s_data.point_y == prev_y_reg) begin
                            if (s_data.path_end) begin
                                pend_reg    <= end_result(prev_x_reg, prev_y_reg,
                                                          start_x_reg, start_y_reg, trav_reg);
                                start_x_reg <= '0;
                                start_y_reg <= '0;
                                prev_x_reg  <= '0;
                                prev_y_reg  <= '0;
                                trav_reg    <= '0;
                                pts_reg     <= '0;
                                sent_reg    <= 1'b0;
                                state_reg   <= S_EMIT;
                            end else begin
                                pts_reg <= 2'd2;
                            end
                        end else begin
                            pts_reg   <= 2'd2;
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    negx_reg  <= dx[MAG_W-1];
                    negy_reg  <= dy[MAG_W-1];
                    magx_reg  <= adx;
                    magy_reg  <= ady;
                    mbx_reg   <= adx;
                    mby_reg   <= ady;
                    accx_reg  <= '0;
                    accy_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL, S_IMUL: begin
                    accx_reg <= addx;
                    accy_reg <= addy;
                    mbx_reg  <= {mbx_reg[MAG_W-2:0], 1'b0};
                    mby_reg  <= {mby_reg[MAG_W-2:0], 1'b0};
                    if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                        step_reg <= '0;
                        rx_reg   <= '0;
                        ry_reg   <= '0;
                        state_reg <= (state_reg == S_MUL) ? S_SUMQ : S_IDIV;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_SUMQ: begin
                    rad_reg   <= RAD_W'(sqsum) << (2 * FRAC_BITS);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    // two radicand bits in, one root bit out
                    rem_reg  <= sq_ge ? (rem_sh - trial) : rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                    rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (reach) begin
                        take_reg  <= remaining;
                        mbx_reg   <= magx_reg;
                        mby_reg   <= magy_reg;
                        accx_reg  <= '0;
                        accy_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_IMUL;
                    end else if (last_reg) begin
                        pend_reg  <= end_result(cur_x_reg, cur_y_reg,
                                                start_x_reg, start_y_reg, trav_sum);
                        start_x_reg <= '0;
                        start_y_reg <= '0;
                        prev_x_reg  <= '0;
                        prev_y_reg  <= '0;
                        trav_reg    <= '0;
                        pts_reg     <= '0;
                        sent_reg    <= 1'b0;
                        state_reg   <= S_EMIT;
                    end else begin
                        trav_reg   <= trav_sum;
                        prev_x_reg <= cur_x_reg;
                        prev_y_reg <= cur_y_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                S_IDIV: begin
                    // restoring division of the product by the segment length
                    rx_reg   <= gex ? ROOT_W'(rsx - {1'b0, root_reg}) : rsx[ROOT_W-1:0];
                    ry_reg   <= gey ? ROOT_W'(rsy - {1'b0, root_reg}) : rsy[ROOT_W-1:0];
                    qx_reg   <= {qx_reg[MAG_W-2:0], gex};
                    qy_reg   <= {qy_reg[MAG_W-2:0], gey};
                    accx_reg <= {accx_reg[ACC_W-2:0], 1'b0};
                    accy_reg <= {accy_reg[ACC_W-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    pend_reg.found_x     <= fx;
                    pend_reg.found_y     <= fy;
                    pend_reg.trim_length <= target_reg;
                    pend_reg.is_valid    <= (fx != start_x_reg || fy != start_y_reg);
                    if (last_reg) begin
                        start_x_reg <= '0;
                        start_y_reg <= '0;
                        prev_x_reg  <= '0;
                        prev_y_reg  <= '0;
                        trav_reg    <= '0;
                        pts_reg     <= '0;
                        sent_reg    <= 1'b0;
                    end else begin
                        sent_reg    <= 1'b1;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= pend_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/pppd_checker.sv]
// pppd_checker: port-level checks for polyline_point_at_distance_core
// depends on pppd_pkg; bound to polyline_point_at_distance_core at the end of this file
module pppd_checker
    import pppd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input pppd_out_t m_data
);

    // a waiting item holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // an offered input item stays offered until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input item withdrawn before accept");

    // an invalid result with no length carries zero coordinates
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_valid && m_data.trim_length == '0 |->
            m_data.found_x == '0 && m_data.found_y == '0)
        else $error("invalid result with nonzero fields");

    // a valid result has travelled some distance
    a_valid_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_valid |-> m_data.trim_length != '0)
        else $error("valid result with zero length");

    // reset leaves no result pending and the input open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state after reset");

endmodule

bind polyline_point_at_distance_core pppd_checker u_pppd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for polyline_point_at_distance_core, with a path tracker class
// depends on pppd_pkg for the item types and widths; needs nothing else but the rtl
module tb_top
    import pppd_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // tracks one polyline at a time and holds the results it should produce
    class path_tracker;
        logic [DIST_W-1:0] target;
        longint            start_x, start_y, prev_x, prev_y;
        logic [63:0]       walked;
        int unsigned       npts;
        bit                done;
        pppd_out_t         pending_q[$];
        int unsigned       errors;
        int unsigned       checked;

        function new();
            target  = '0;
            errors  = 0;
            checked = 0;
            clear_path();
        endfunction

        function void clear_path();
            start_x = 0; start_y = 0; prev_x = 0; prev_y = 0;
            walked  = 0;
            npts    = 0;
            done    = 0;
        endfunction

        function void set_target(logic [DIST_W-1:0] v);
            target = v;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // floor(sqrt((ax^2 + ay^2) * 2^(2*frac)))
        function logic [63:0] seg_len(logic [63:0] ax, logic [63:0] ay);
            logic [127:0] rad;
            logic [127:0] c;
            logic [63:0]  root;
            rad  = ({64'b0, ax} * ax + {64'b0, ay} * ay) << (2 * FRAC_BITS);
            root = 0;
            for (int b = 50; b >= 0; b--) begin
                c = {64'b0, root | (64'd1 << b)};
                if (c * c <= rad) begin
                    root = c[63:0];
                end
            end
            return root;
        endfunction

        // p + d*take/len, exact, then truncated toward zero
        function longint lerp(longint p, longint d, logic [63:0] take, logic [63:0] len);
            logic [127:0] prod;
            logic [127:0] q;
            logic [127:0] r;
            logic [63:0]  m;
            longint       fl, ce, s;
            m    = (d < 0) ? -d : d;
            prod = {64'b0, m} * take;
            q    = prod / len;
            r    = prod % len;
            if (d >= 0) begin
                fl = longint'(q[63:0]);
                ce = longint'(q[63:0]) + ((r != 0) ? 1 : 0);
            end else begin
                fl = -longint'(q[63:0]) - ((r != 0) ? 1 : 0);
                ce = -longint'(q[63:0]);
            end
            s = p + fl;
            return (s >= 0) ? s : p + ce;
        endfunction

        function void push(longint x, longint y, logic [63:0] len, bit ok);
            pppd_out_t r;
            r.found_x     = x[COORD_W-1:0];
            r.found_y     = y[COORD_W-1:0];
            r.trim_length = (len > {16'b0, DIST_MAX}) ? DIST_MAX : len[DIST_W-1:0];
            r.is_valid    = ok;
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void note_point(pppd_in_t it);
            longint      x, y, dx, dy, fx, fy;
            logic [63:0] len, rem, trim;
            bit          ok;
            x = longint'(it.point_x);
            y = longint'(it.point_y);
            if (!done) begin
                if (npts == 0) begin
                    start_x = x; start_y = y;
                    prev_x  = x; prev_y  = y;
                    walked  = 0;
                    npts    = 1;
                    if (target == 0) begin
                        push(0, 0, 0, 1'b0);
                        done = 1;
                    end
                end else begin
                    npts = 2;
                    if (x != prev_x || y != prev_y) begin
                        dx  = x - prev_x;
                        dy  = y - prev_y;
                        len = seg_len((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
                        rem = {16'b0, target} - walked;
                        if (rem <= len) begin
                            fx   = lerp(prev_x, dx, rem, len);
                            fy   = lerp(prev_y, dy, rem, len);
                            trim = walked + rem;
                            ok   = (fx != start_x || fy != start_y) && trim > 0;
                            push(fx, fy, trim, ok);
                            done = 1;
                        end else begin
                            walked = walked + len;
                            prev_x = x; prev_y = y;
                        end
                    end
                end
                if (it.path_end && !done) begin
                    if (npts < 2 || walked == 0 || (prev_x == start_x && prev_y == start_y)) begin
                        push(0, 0, 0, 1'b0);
                    end else begin
                        push(prev_x, prev_y, walked, 1'b1);
                    end
                end
            end
            if (it.path_end) begin
                clear_path();
            end
        endfunction

        function void check_result(pppd_out_t got);
            pppd_out_t want;
            checked++;
            if (pending_q.size() == 0) begin
                $error("unexpected result item x=%0d y=%0d len=%0d valid=%0b",
                       got.found_x, got.found_y, got.trim_length, got.is_valid);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.found_x !== want.found_x) begin
                $error("found_x expected %0d actual %0d", want.found_x, got.found_x);
                errors++;
            end
            if (got.found_y !== want.found_y) begin
                $error("found_y expected %0d actual %0d", want.found_y, got.found_y);
                errors++;
            end
            if (got.trim_length !== want.trim_length) begin
                $error("trim_length expected %0d actual %0d", want.trim_length, got.trim_length);
                errors++;
            end
            if (got.is_valid !== want.is_valid) begin
                $error("is_valid expected %0b actual %0b", want.is_valid, got.is_valid);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [DIST_W-1:0] cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pppd_in_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pppd_out_t         m_data;

    path_tracker sb = new();

    int          hold_req = 0;
    int          hold_cnt = 0;
    int          rx_mode = 0;
    int          rx_left = 0;
    int          burst_left = 0;
    int          idle_cnt = 0;
    int unsigned points_sent = 0;

    always #5 aclk = ~aclk;

    polyline_point_at_distance_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // receiver: changing stall patterns, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left <= 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= $urandom_range(0, 1);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // result checking and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cnt = 0;
            end else begin
                idle_cnt++;
                if (idle_cnt >= WATCHDOG_LIMIT) begin
                    $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    task automatic drain();
        // no item is offered while waiting
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_target(logic [DIST_W-1:0] v);
        drain();
        // a point that gives no item may still be in the datapath
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_target(v);
    endtask

    task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
        s_data  <= '{point_x: x, point_y: y, path_end: last};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_point(s_data);
        points_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(0, 20);
        end
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(int unsigned span);
        if (span == 0) begin
            return $urandom();
        end
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // one random path; mostly well formed, some repeats and single points
    task automatic send_rand_path();
        int unsigned        span;
        int unsigned        npts;
        logic [COORD_W-1:0] x, y;
        case ($urandom_range(0, 3))
            0: span = 16;
            1: span = 4096;
            2: span = 100;
            default: span = 0;
        endcase
        npts = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
        x = rand_coord(span);
        y = rand_coord(span);
        for (int i = 0; i < npts; i++) begin
            if (i > 0 && $urandom_range(0, 6) != 0) begin
                x = x + rand_coord(span);
                y = y + rand_coord(span);
            end
            send_point(x, y, i == npts - 1);
        end
    endtask

    initial begin
        logic [DIST_W-1:0] tgt;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero target: invalid item at the first point, rest of path ignored
        write_target('0);
        send_point(5, 5, 1'b0);
        send_point(10, 10, 1'b1);
        send_point(7, 7, 1'b1);

        // repeated points, exact hit on a segment end, path ending short
        write_target(DIST_W'(10 * 256));
        send_point(3, 4, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(3, 4, 1'b0);
        send_point(3, 4, 1'b0);
        send_point(6, 8, 1'b0);
        send_point(9, 12, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(3, 4, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(3, 4, 1'b0);
        send_point(0, 0, 1'b1);
        write_target(DIST_W'(2567));
        send_point(-7, -3, 1'b0);
        send_point(-1, 5, 1'b1);

        // largest target: extremes, returning to start, zero total length
        write_target(DIST_MAX);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        send_point(1, 1, 1'b0);
        send_point(2, 2, 1'b0);
        send_point(1, 1, 1'b1);
        send_point(4, 4, 1'b0);
        send_point(4, 4, 1'b1);

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 2) begin
                tgt = '0;
            end else if (ph == 5) begin
                tgt = DIST_MAX;
            end else if (ph == 8) begin
                tgt = DIST_W'({$urandom(), $urandom()});
            end else begin
                tgt = DIST_W'(256 * $urandom_range(1, 60) + $urandom_range(0, 255));
            end
            write_target(tgt);
            if (ph == 3) begin
                hold_req = 1500;
            end
            while (points_sent < 25 + (ph + 1) * 40) begin
                send_rand_path();
                if (ph == 6 && points_sent > 25 + ph * 40 + 20 && sb.pending() != 0) begin
                    drain();
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("sent %0d points over paths at zero, small, random and maximum targets",
                 points_sent);
        $display("checked %0d result items under sender gaps and receiver stalls", sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
